### rtl/tcf_pkg.sv
// Shared constants and types for the text_cat_filter block.
package tcf_pkg;

   // Default width of the printed line number, in decimal digits.
   localparam int NumberDigitsDefault = 6;

   // Extra output bytes beyond the number digits: tab plus up to four shown bytes.
   localparam int ExtraBytes = 5;

   // Shown form of one input byte is at most four bytes ("M-^X").
   localparam int ShownMax = 4;

   // Character codes.
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharLf     = 8'h0A;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharDash   = 8'h2D;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharQuery  = 8'h3F;
   localparam logic [7:0] CharUpperI = 8'h49;
   localparam logic [7:0] CharUpperM = 8'h4D;
   localparam logic [7:0] CharCaret  = 8'h5E;
   localparam logic [7:0] CharDel    = 8'h7F;
   localparam logic [7:0] CtrlMax    = 8'h1F;
   localparam logic [7:0] CaretBias  = 8'h40;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_NUMBER_ALL       = 3'd0,
      REG_NUMBER_NONBLANK  = 3'd1,
      REG_SQUEEZE_BLANK    = 3'd2,
      REG_SHOW_ENDS        = 3'd3,
      REG_SHOW_TABS        = 3'd4,
      REG_SHOW_NONPRINTING = 3'd5
   } csr_reg_type;

   // Option bits held by the block.
   typedef struct packed {
      logic number_all;
      logic number_nonblank;
      logic squeeze_blank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } options_type;

endpackage

### rtl/text_cat_filter.sv
// text_cat_filter: byte-stream text filter with line numbering and visible control bytes.

// Takes text one byte per transaction on req_ and emits the transformed bytes on rsp_,
// with rsp_run_last marking the final byte produced by each input byte. An input byte
// that begins a line may first produce a NUMBER_DIGITS-wide space-padded decimal line
// number and a tab; the byte itself then yields one to four bytes (caret, M- and '$'
// forms). A squeezed empty line produces no output at all. A two-entry input queue
// feeds one expansion stage, which builds the whole output run of a byte into a shift
// register that drains one byte per cycle to rsp_ while rsp_stall is low. An input
// byte is therefore taken every cycle while each yields one output byte; a byte that
// expands to k bytes (up to NUMBER_DIGITS+5) holds the drain register until all k are
// taken, so the output port sets the rate.
// Options are written through csr_ (always ready, bit 0 of the data kept) and must
// only change while the block is idle.
module text_cat_filter #(
   parameter int NUMBER_DIGITS = tcf_pkg::NumberDigitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   // input byte stream
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   // output byte stream
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   // option registers
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic       csr_wdata
);

   localparam int MaxRun  = NUMBER_DIGITS + tcf_pkg::ExtraBytes;
   localparam int CntW    = $clog2(MaxRun + 1);
   localparam int BcdW    = 4 * NUMBER_DIGITS;

   // ---------------- options ----------------
   tcf_pkg::options_type opt_ff, opt_in;

   assign csr_ready = 1'b1;

   always_comb begin
      opt_in = opt_ff;
      if (csr_valid) begin
         unique case (tcf_pkg::csr_reg_type'(csr_index))
            tcf_pkg::REG_NUMBER_ALL:       opt_in.number_all       = csr_wdata;
            tcf_pkg::REG_NUMBER_NONBLANK:  opt_in.number_nonblank  = csr_wdata;
            tcf_pkg::REG_SQUEEZE_BLANK:    opt_in.squeeze_blank    = csr_wdata;
            tcf_pkg::REG_SHOW_ENDS:        opt_in.show_ends        = csr_wdata;
            tcf_pkg::REG_SHOW_TABS:        opt_in.show_tabs        = csr_wdata;
            tcf_pkg::REG_SHOW_NONPRINTING: opt_in.show_nonprinting = csr_wdata;
            default:                       opt_in                  = opt_ff;
         endcase
      end
   end

   // ---------------- input queue (two entries) ----------------
   logic [7:0] fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fifo_cnt_ff, fifo_cnt_in;
   logic       push, pop;
   logic [7:0] cur_byte;

   // stall comes from registers only, so the two sides stay decoupled
   assign req_stall = fifo_cnt_ff[1];
   assign push      = req_valid && !req_stall;
   assign cur_byte  = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in   = wr_ptr_ff ^ push;
      rd_ptr_in   = rd_ptr_ff ^ pop;
      fifo_cnt_in = fifo_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // ---------------- line state ----------------
   logic [BcdW-1:0] bcd_ff, bcd_in;
   logic            at_start_ff, at_start_in;
   logic            prev_empty_ff, prev_empty_in;

   // ---------------- drain register ----------------
   logic [7:0]      run_ff [MaxRun];
   logic [7:0]      run_in [MaxRun];
   logic [CntW-1:0] run_cnt_ff, run_cnt_in;
   logic            take;

   assign rsp_valid    = (run_cnt_ff != '0);
   assign rsp_out_byte = run_ff[0];
   assign rsp_run_last = (run_cnt_ff == CntW'(1));
   assign take         = rsp_valid && !rsp_stall;

   // next item may enter once the drain register is empty or emptying this cycle
   assign pop = (fifo_cnt_ff != 2'd0) &&
                ((run_cnt_ff == '0) || (run_cnt_ff == CntW'(1) && !rsp_stall));

   // ---------------- expansion of the current byte ----------------
   logic            is_lf, squeeze, emit_num;
   logic [7:0]      num_chr [NUMBER_DIGITS];
   logic [BcdW-1:0] bcd_inc;
   logic [7:0]      shown   [tcf_pkg::ShownMax];
   logic [2:0]      shown_n;
   logic [CntW-1:0] ld_cnt;
   logic [7:0]      fill    [MaxRun];

   assign is_lf    = (cur_byte == tcf_pkg::CharLf);
   assign squeeze  = at_start_ff && is_lf && prev_empty_ff && opt_ff.squeeze_blank;
   assign emit_num = at_start_ff && !squeeze &&
                     (opt_ff.number_nonblank ? !is_lf : opt_ff.number_all);

   // number text with leading zeros blanked; the units digit always shows
   always_comb begin
      logic       seen;
      logic [3:0] dig;
      seen = 1'b0;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
         dig  = bcd_ff[4*i +: 4];
         seen = seen || (dig != 4'd0) || (i == 0);
         num_chr[NUMBER_DIGITS-1-i] = seen ? (tcf_pkg::CharZero | {4'd0, dig})
                                           : tcf_pkg::CharSpace;
      end
   end

   // BCD increment, held at all nines
   always_comb begin
      logic       carry, full;
      logic [3:0] dig;
      carry   = 1'b1;
      full    = 1'b1;
      bcd_inc = bcd_ff;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         dig = bcd_ff[4*i +: 4];
         if (dig != 4'd9) full = 1'b0;
         if (carry) begin
            if (dig >= 4'd9) begin
               bcd_inc[4*i +: 4] = 4'd0;
            end else begin
               bcd_inc[4*i +: 4] = dig + 4'd1;
               carry             = 1'b0;
            end
         end
      end
      if (full) bcd_inc = bcd_ff;
   end

   // shown form of the byte: optional '$' or "M-", optional '^', then the character
   always_comb begin
      logic       dollar, mdash, caret;
      logic [7:0] low, ch;
      dollar = 1'b0;
      mdash  = 1'b0;
      caret  = 1'b0;
      low    = {1'b0, cur_byte[6:0]};
      ch     = cur_byte;
      if (opt_ff.show_tabs && cur_byte == tcf_pkg::CharTab) begin
         caret = 1'b1;
         ch    = tcf_pkg::CharUpperI;
      end else begin
         dollar = opt_ff.show_ends &&
                  (cur_byte == tcf_pkg::CharLf || cur_byte == tcf_pkg::CharCr);
         if (opt_ff.show_nonprinting) begin
            if (cur_byte[7]) begin
               mdash = 1'b1;
               ch    = low;
               if (low <= tcf_pkg::CtrlMax) begin
                  caret = 1'b1;
                  ch    = low + tcf_pkg::CaretBias;
               end else if (low == tcf_pkg::CharDel) begin
                  caret = 1'b1;
                  ch    = tcf_pkg::CharQuery;
               end
            end else if (cur_byte <= tcf_pkg::CtrlMax && cur_byte != tcf_pkg::CharLf &&
                         cur_byte != tcf_pkg::CharCr && cur_byte != tcf_pkg::CharTab) begin
               caret = 1'b1;
               ch    = cur_byte + tcf_pkg::CaretBias;
            end else if (cur_byte == tcf_pkg::CharDel) begin
               caret = 1'b1;
               ch    = tcf_pkg::CharQuery;
            end
         end
      end
      for (int k = 0; k < tcf_pkg::ShownMax; k++) shown[k] = 8'd0;
      if (mdash) begin
         shown[0] = tcf_pkg::CharUpperM;
         shown[1] = tcf_pkg::CharDash;
         shown[2] = caret ? tcf_pkg::CharCaret : ch;
         shown[3] = ch;
         shown_n  = caret ? 3'd4 : 3'd3;
      end else if (dollar) begin
         shown[0] = tcf_pkg::CharDollar;
         shown[1] = ch;
         shown_n  = 3'd2;
      end else if (caret) begin
         shown[0] = tcf_pkg::CharCaret;
         shown[1] = ch;
         shown_n  = 3'd2;
      end else begin
         shown[0] = ch;
         shown_n  = 3'd1;
      end
   end

   // assemble the whole run: number and tab (if any), then the shown form
   always_comb begin
      for (int i = 0; i < MaxRun; i++) begin
         if (emit_num) begin
            if (i < NUMBER_DIGITS)
               fill[i] = num_chr[i];
            else if (i == NUMBER_DIGITS)
               fill[i] = tcf_pkg::CharTab;
            else
               fill[i] = shown[2'(i - NUMBER_DIGITS - 1)];
         end else begin
            fill[i] = (i < tcf_pkg::ShownMax) ? shown[2'(i)] : 8'd0;
         end
      end
      if (squeeze)
         ld_cnt = '0;
      else if (emit_num)
         ld_cnt = CntW'(NUMBER_DIGITS + 1) + CntW'(shown_n);
      else
         ld_cnt = CntW'(shown_n);
   end

   // ---------------- next state ----------------
   always_comb begin
      bcd_in        = bcd_ff;
      at_start_in   = at_start_ff;
      prev_empty_in = prev_empty_ff;
      if (pop && !squeeze) begin
         at_start_in = is_lf;
         if (at_start_ff) prev_empty_in = is_lf;
         if (emit_num) bcd_in = bcd_inc;
      end
   end

   always_comb begin
      run_in     = run_ff;
      run_cnt_in = run_cnt_ff;
      if (pop) begin
         run_in     = fill;
         run_cnt_in = ld_cnt;
      end else if (take) begin
         for (int i = 0; i < MaxRun - 1; i++) run_in[i] = run_ff[i+1];
         run_cnt_in = run_cnt_ff - CntW'(1);
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         opt_ff        <= '0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         fifo_cnt_ff   <= 2'd0;
         bcd_ff        <= BcdW'(1);
         at_start_ff   <= 1'b1;
         prev_empty_ff <= 1'b0;
         run_cnt_ff    <= '0;
      end else begin
         opt_ff        <= opt_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_cnt_ff   <= fifo_cnt_in;
         bcd_ff        <= bcd_in;
         at_start_ff   <= at_start_in;
         prev_empty_ff <= prev_empty_in;
         run_cnt_ff    <= run_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= req_in_byte;
      run_ff <= run_in;
   end

`ifndef SYNTHESIS
   // queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= 2'd2)
      else $error("input queue count out of range");

   // a byte that is not squeezed always shows up on the output next cycle
   a_run_loaded: assert property (@(posedge clock) disable iff (reset)
      pop && !squeeze |=> rsp_valid)
      else $error("loaded run did not reach output");

   // a byte other than LF always leaves the block mid-line
   a_mid_line: assert property (@(posedge clock) disable iff (reset)
      pop && !is_lf |=> !at_start_ff)
      else $error("line start set after non-LF byte");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for text_cat_filter: random and directed byte streams against a predictor.
module tb_top;

   localparam int NumDigits = tcf_pkg::NumberDigitsDefault;
   localparam int HoldCycles = 300;   // long receiver hold-off, fills the input queue
   localparam int SettleCycles = 20;  // covers latency plus a squeezed byte still in flight
   localparam int PhaseItems = 18;

   // One output transaction as seen on rsp_.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } out_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_in_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_run_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   tcf_pkg::csr_reg_type csr_index = tcf_pkg::REG_NUMBER_ALL;
   logic                 csr_wdata = 1'b0;

   // Bytes waiting to be offered, and output bytes the filter still owes us.
   logic [7:0]    text_in[$];
   out_beat_type  text_out_due[$];

   // Predictor copy of the block's state and options (values as after reset).
   tcf_pkg::options_type     opts_now = '0;
   logic [4*NumDigits-1:0]   line_bcd = (4*NumDigits)'(1);
   logic                     at_start = 1'b1;
   logic                     prev_empty = 1'b0;

   int n_pushed = 0;
   int n_taken = 0;
   int n_checked = 0;
   int n_squeezed = 0;
   int n_numbered = 0;
   int errors = 0;

   // Idling controls: gaps_on enables random idle cycles, hold_* drive the long hold-off.
   bit gaps_on = 1'b1;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;

   always #5 clock = ~clock;

   text_cat_filter i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Works out the output run for one accepted input byte and queues it.
   function automatic void filter_byte(input logic [7:0] b);
      logic [7:0] run[$];
      logic [7:0] c;
      logic [3:0] d;
      logic       lf_line;
      logic       lead;
      logic       carry;
      logic       plain;
      c = b;
      if (at_start) begin
         lf_line = (b == tcf_pkg::CharLf);
         // repeated empty line under squeeze: nothing out, state untouched
         if (lf_line && prev_empty && opts_now.squeeze_blank) begin
            n_squeezed++;
            return;
         end
         prev_empty = lf_line;
         // nonblank mode takes precedence over number-all
         if (opts_now.number_nonblank ? !lf_line : opts_now.number_all) begin
            lead = 1'b1;
            for (int i = NumDigits - 1; i >= 0; i--) begin
               d = line_bcd[4*i +: 4];
               if (d != 4'd0 || i == 0) lead = 1'b0;
               run.push_back(lead ? tcf_pkg::CharSpace : tcf_pkg::CharZero + 8'(d));
            end
            run.push_back(tcf_pkg::CharTab);
            n_numbered++;
            // BCD increment, sticking at all nines
            if (line_bcd != {NumDigits{4'h9}}) begin
               carry = 1'b1;
               for (int i = 0; i < NumDigits; i++) begin
                  if (carry) begin
                     if (line_bcd[4*i +: 4] >= 4'h9) begin
                        line_bcd[4*i +: 4] = 4'h0;
                     end else begin
                        line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'h1;
                        carry = 1'b0;
                     end
                  end
               end
            end
         end
      end
      at_start = (b == tcf_pkg::CharLf);

      // Shown form of the byte itself; show-tabs wins over caret notation for a tab.
      if (opts_now.show_tabs && b == tcf_pkg::CharTab) begin
         run.push_back(tcf_pkg::CharCaret);
         run.push_back(tcf_pkg::CharUpperI);
      end else begin
         if (opts_now.show_ends && (b == tcf_pkg::CharLf || b == tcf_pkg::CharCr))
            run.push_back(tcf_pkg::CharDollar);
         plain = 1'b1;
         if (opts_now.show_nonprinting) begin
            if (c[7]) begin
               run.push_back(tcf_pkg::CharUpperM);
               run.push_back(tcf_pkg::CharDash);
               c[7] = 1'b0;
            end
            // high bytes get caret form for every low control code, LF/CR/tab included
            if (c <= tcf_pkg::CtrlMax &&
                (b[7] || (c != tcf_pkg::CharLf && c != tcf_pkg::CharCr &&
                          c != tcf_pkg::CharTab))) begin
               run.push_back(tcf_pkg::CharCaret);
               run.push_back(c + tcf_pkg::CaretBias);
               plain = 1'b0;
            end else if (c == tcf_pkg::CharDel) begin
               run.push_back(tcf_pkg::CharCaret);
               run.push_back(tcf_pkg::CharQuery);
               plain = 1'b0;
            end
         end
         if (plain) run.push_back(c);
      end

      foreach (run[k])
         text_out_due.push_back('{out_byte: run[k], run_last: (k == run.size() - 1)});
   endfunction

   task automatic note_error(input string what, input out_beat_type want,
                             input out_beat_type got);
      errors++;
      if (errors <= 10) begin
         $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $time, what, want.out_byte, want.run_last, got.out_byte, got.run_last);
      end
   endtask

   // Sender: one transaction per accepted byte; valid is held until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_in_byte <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_byte(req_in_byte);
            n_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (text_in.size() != 0 && !(gaps_on && $urandom_range(99) < 7)) begin
               req_valid <= 1'b1;
               req_in_byte <= text_in.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off counter, restarted each time the stimulus asks for one.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HoldCycles;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: checks each accepted output transaction against the oldest expectation.
   always @(posedge clock) begin
      out_beat_type due;
      out_beat_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{out_byte: rsp_out_byte, run_last: rsp_run_last};
            if (text_out_due.size() == 0) begin
               note_error("unexpected output", '0, got);
            end else begin
               due = text_out_due.pop_front();
               n_checked++;
               if (due.out_byte !== got.out_byte) note_error("byte mismatch", due, got);
               else if (due.run_last !== got.run_last) note_error("run_last mismatch", due, got);
            end
         end
         rsp_stall <= (hold_left != 0) || (gaps_on && $urandom_range(99) < 7);
      end
   end

   // Queues one byte for the sender; called on the falling edge to stay clear of it.
   task automatic feed(input logic [7:0] b);
      text_in.push_back(b);
      n_pushed++;
   endtask

   // Text-like bytes with plenty of line breaks, plus a share of arbitrary bytes.
   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 25) return tcf_pkg::CharLf;
      if (r < 30) return tcf_pkg::CharCr;
      if (r < 35) return tcf_pkg::CharTab;
      if (r < 75) return 8'($urandom_range(126, 32));
      return 8'($urandom_range(255));
   endfunction

   // Waits until every byte is taken and every expected output has arrived, then lets
   // the block settle in case a squeezed byte is still inside it.
   task automatic settle();
      do @(negedge clock); while (n_taken != n_pushed || text_out_due.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Writes all six option registers back to back, then drops valid once.
   task automatic set_options(input tcf_pkg::options_type o);
      tcf_pkg::csr_reg_type idx;
      logic                 bit_v;
      @(posedge clock);
      for (int i = 0; i <= int'(tcf_pkg::REG_SHOW_NONPRINTING); i++) begin
         idx = tcf_pkg::csr_reg_type'(i);
         case (idx)
            tcf_pkg::REG_NUMBER_ALL:       bit_v = o.number_all;
            tcf_pkg::REG_NUMBER_NONBLANK:  bit_v = o.number_nonblank;
            tcf_pkg::REG_SQUEEZE_BLANK:    bit_v = o.squeeze_blank;
            tcf_pkg::REG_SHOW_ENDS:        bit_v = o.show_ends;
            tcf_pkg::REG_SHOW_TABS:        bit_v = o.show_tabs;
            default:                       bit_v = o.show_nonprinting;
         endcase
         csr_index <= idx;
         csr_wdata <= bit_v;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      opts_now = o;
      @(negedge clock);
   endtask

   initial begin
      tcf_pkg::options_type o;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Everything on: both numbering modes, squeeze, ends, tabs and caret/M- forms.
      set_options('1);
      feed(8'h41);
      feed(tcf_pkg::CharLf);
      feed(tcf_pkg::CharLf);   // first empty line, shown as "$\n"
      feed(tcf_pkg::CharLf);   // second empty line, dropped by squeeze
      feed(tcf_pkg::CharTab);  // tab under both show options gives ^I
      feed(8'hFF);             // high DEL gives M-^?
      feed(8'h80);
      feed(8'h9F);
      feed(8'hA0);
      feed(tcf_pkg::CharDel);
      feed(8'h00);
      feed(tcf_pkg::CtrlMax);
      feed(tcf_pkg::CharCr);
      feed(tcf_pkg::CharLf);
      feed(8'hFF);             // numbered line opening with M-^?: the longest run
      feed(tcf_pkg::CharLf);

      // Everything off: bytes should pass straight through.
      settle();
      set_options('0);
      feed(8'h00);
      feed(8'hFF);
      feed(tcf_pkg::CharTab);
      feed(tcf_pkg::CharLf);
      feed(tcf_pkg::CharLf);
      feed(tcf_pkg::CharLf);
      feed(8'h41);
      feed(tcf_pkg::CharLf);

      // Random option sets; one phase with no idling, one with a long receiver hold-off.
      for (int p = 0; p < 6; p++) begin
         settle();
         o = tcf_pkg::options_type'(6'($urandom_range(63)));
         set_options(o);
         gaps_on = (p != 2);
         if (p == 4) hold_asked++;
         repeat (PhaseItems) feed(pick_text_byte());
      end

      settle();
      $display("%0d input bytes, %0d output bytes checked, %0d lines numbered, %0d squeezed",
               n_taken, n_checked, n_numbered, n_squeezed);
      $display("option sets: all on, all off and six random, with a %0d-cycle hold-off",
               HoldCycles);
      if (errors == 0 && text_out_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d errors", errors);
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

endmodule
